@@ design/bounded_deque_with_search_top_assert.svh @@
// ----------------------------------------------------------------------------
// bounded deque assertion macros
// shorthand for clocked concurrent assertions with an active-low reset guard
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define BDQ_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define BDQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// shared types and constants of the bounded deque with search
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH      = 16;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int HANDLE_W   = 32;
    localparam int REQ_W      = 3;
    localparam int STAT_W     = 2;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = CNT_W'(DEPTH);

    // register index, taken from paddr above the byte offset
    localparam logic [ADDR_W-3:0] REG_MAX_ENTRIES = '0;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_REAR,
        OP_POP_FRONT,
        OP_POP_REAR,
        OP_SEARCH,
        OP_REMOVE,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [HANDLE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [HANDLE_W-1:0] data;
        logic [IDX_W-1:0]    position;
        logic [CNT_W-1:0]    entry_count;
    } rsp_t;

    typedef struct packed {
        op_t                 op;
        logic [HANDLE_W-1:0] value;
    } cmd_t;

endpackage

@@ design/bdq_front.sv @@
// ----------------------------------------------------------------------------
// bdq_front
// accepts request transactions and classifies them into commands
// ----------------------------------------------------------------------------
module bdq_front
    import bdq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic cmd_valid,
    input  logic cmd_ready,
    output cmd_t cmd_data
);

    logic cmd_valid_reg;
    logic cmd_valid_next;
    cmd_t cmd_reg;
    op_t  op_class;

    always_comb begin
        unique case (s_data.req_type)
            REQ_PUSH_FRONT: op_class = OP_PUSH_FRONT;
            REQ_PUSH_REAR:  op_class = OP_PUSH_REAR;
            REQ_POP_FRONT:  op_class = OP_POP_FRONT;
            REQ_POP_REAR:   op_class = OP_POP_REAR;
            REQ_SEARCH:     op_class = OP_SEARCH;
            REQ_REMOVE:     op_class = OP_REMOVE;
            default:        op_class = OP_NOP;
        endcase
    end

    assign s_ready = !cmd_valid_reg || cmd_ready;

    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        if (cmd_valid_reg && cmd_ready) begin
            cmd_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            cmd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg.op    <= op_class;
            cmd_reg.value <= s_data.value;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd_data  = cmd_reg;

endmodule

@@ design/bdq_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// bdq_cmd_fifo
// short command queue between the front and back sections
// ----------------------------------------------------------------------------
module bdq_cmd_fifo
    import bdq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int LVL_W = FIFO_PTR_W + 1;

    cmd_t                  slot_q [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [LVL_W-1:0]      level_reg;
    logic [LVL_W-1:0]      level_next;
    logic                  do_wr;
    logic                  do_rd;

    assign in_ready  = (level_reg != LVL_W'(FIFO_DEPTH));
    assign out_valid = (level_reg != '0);
    assign out_cmd   = slot_q[rd_ptr_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_wr) begin
            wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            level_next = level_reg + LVL_W'(1);
        end else if (!do_wr && do_rd) begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_q[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ design/bdq_back.sv @@
// ----------------------------------------------------------------------------
// bdq_back
// executes commands on the circular entry store and forms the results
// ----------------------------------------------------------------------------
module bdq_back
    import bdq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] max_entries,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rsp_t             m_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [HANDLE_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [HANDLE_W-1:0] hit_data_reg, hit_data_next;
    logic [IDX_W-1:0]    hit_pos_reg, hit_pos_next;
    logic                m_valid_reg, m_valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic [HANDLE_W-1:0] mem [DEPTH];
    logic [HANDLE_W-1:0] rdata_reg;
    logic [IDX_W-1:0]    raddr;
    logic [IDX_W-1:0]    waddr;
    logic [HANDLE_W-1:0] wdata;
    logic                mem_we;

    logic [CNT_W-1:0]    limit;
    logic                out_free;
    logic                scan_last;
    logic                shift_more;
    logic [CNT_W-1:0]    count_dec;

    function automatic rsp_t make_rsp(logic [STAT_W-1:0] st, logic [HANDLE_W-1:0] d,
                                      logic [IDX_W-1:0] p, logic [CNT_W-1:0] c);
        rsp_t r;
        r.status      = st;
        r.data        = d;
        r.position    = p;
        r.entry_count = c;
        return r;
    endfunction

    assign limit      = (max_entries > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : max_entries;
    assign out_free   = !m_valid_reg || m_ready;
    assign scan_last  = (({1'b0, idx_reg} + CNT_W'(1)) == count_reg);
    assign shift_more = (({1'b0, idx_reg} + CNT_W'(2)) < count_reg);
    assign count_dec  = count_reg - CNT_W'(1);

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        hit_data_next = hit_data_reg;
        hit_pos_next  = hit_pos_reg;
        m_valid_next  = m_valid_reg;
        rsp_next      = rsp_reg;
        cmd_ready     = 1'b0;
        mem_we        = 1'b0;
        waddr         = front_reg + idx_reg;
        wdata         = rdata_reg;
        raddr         = front_reg + idx_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready = 1'b1;
                    op_next   = cmd_data.op;
                    key_next  = cmd_data.value;
                    unique case (cmd_data.op)
                        OP_PUSH_FRONT, OP_PUSH_REAR: begin
                            m_valid_next = 1'b1;
                            if (count_reg >= limit) begin
                                rsp_next = make_rsp(ST_FULL, '0, '0, count_reg);
                            end else begin
                                mem_we     = 1'b1;
                                wdata      = cmd_data.value;
                                count_next = count_reg + CNT_W'(1);
                                if (cmd_data.op == OP_PUSH_FRONT) begin
                                    waddr      = front_reg - IDX_W'(1);
                                    front_next = front_reg - IDX_W'(1);
                                end else begin
                                    waddr = front_reg + count_reg[IDX_W-1:0];
                                end
                                rsp_next = make_rsp(ST_OK, '0, '0, count_reg + CNT_W'(1));
                            end
                        end
                        OP_POP_FRONT, OP_POP_REAR: begin
                            if (count_reg == '0) begin
                                m_valid_next = 1'b1;
                                rsp_next     = make_rsp(ST_EMPTY, '0, '0, count_reg);
                            end else begin
                                if (cmd_data.op == OP_POP_FRONT) begin
                                    raddr = front_reg;
                                end else begin
                                    raddr = front_reg + count_dec[IDX_W-1:0];
                                end
                                state_next = S_POP;
                            end
                        end
                        OP_SEARCH, OP_REMOVE: begin
                            if (count_reg == '0) begin
                                m_valid_next = 1'b1;
                                rsp_next     = make_rsp(ST_NOTFOUND, '0, '0, count_reg);
                            end else begin
                                raddr      = front_reg;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            rsp_next     = make_rsp(ST_OK, '0, '0, count_reg);
                        end
                    endcase
                end
            end
            S_POP: begin
                m_valid_next = 1'b1;
                rsp_next     = make_rsp(ST_OK, rdata_reg, '0, count_dec);
                count_next   = count_dec;
                if (op_reg == OP_POP_FRONT) begin
                    front_next = front_reg + IDX_W'(1);
                end
                state_next = S_IDLE;
            end
            S_SCAN: begin
                if (rdata_reg == key_reg) begin
                    hit_data_next = rdata_reg;
                    hit_pos_next  = idx_reg;
                    if (op_reg == OP_SEARCH) begin
                        m_valid_next = 1'b1;
                        rsp_next     = make_rsp(ST_OK, rdata_reg, idx_reg, count_reg);
                        state_next   = S_IDLE;
                    end else if (scan_last) begin
                        m_valid_next = 1'b1;
                        rsp_next     = make_rsp(ST_OK, rdata_reg, idx_reg, count_dec);
                        count_next   = count_dec;
                        state_next   = S_IDLE;
                    end else begin
                        raddr      = front_reg + idx_reg + IDX_W'(1);
                        state_next = S_SHIFT;
                    end
                end else if (scan_last) begin
                    m_valid_next = 1'b1;
                    rsp_next     = make_rsp(ST_NOTFOUND, '0, '0, count_reg);
                    state_next   = S_IDLE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                    raddr    = front_reg + idx_reg + IDX_W'(1);
                end
            end
            S_SHIFT: begin
                // rdata holds the entry one place behind the slot being filled
                mem_we = 1'b1;
                waddr  = front_reg + idx_reg;
                wdata  = rdata_reg;
                if (shift_more) begin
                    idx_next = idx_reg + IDX_W'(1);
                    raddr    = front_reg + idx_reg + IDX_W'(2);
                end else begin
                    m_valid_next = 1'b1;
                    rsp_next     = make_rsp(ST_OK, hit_data_reg, hit_pos_reg, count_dec);
                    count_next   = count_dec;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        hit_data_reg <= hit_data_next;
        hit_pos_reg  <= hit_pos_next;
        rsp_reg      <= rsp_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

endmodule

@@ design/bounded_deque_with_search_top.sv @@
// path: requests pass the front register and command FIFO; push, refused push, error and
// unused requests are answered by the result register; pops read, then finish in S_POP;
// search and removal read one entry per cycle in S_SCAN, removal then shifts in S_SHIFT
// throughput: a push or error request every cycle unless stalled; none while not S_IDLE
// reset: synchronous active low; deque empties, max_entries returns to 16, store not cleared
// ----------------------------------------------------------------------------
// bounded_deque_with_search_top
// bounded double-ended queue of handles with search and remove by value
// ----------------------------------------------------------------------------
module bounded_deque_with_search_top
    import bdq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  req_t              s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rsp_t              m_data
);

    logic [CNT_W-1:0]  max_entries_reg;
    logic [ADDR_W-3:0] reg_sel;
    logic              cfg_wr;
    logic              front_valid;
    logic              front_ready;
    cmd_t              front_cmd;
    logic              back_valid;
    logic              back_ready;
    cmd_t              back_cmd;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_sel == REG_MAX_ENTRIES) ? DATA_W'(max_entries_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= MAX_ENTRIES_RST;
        end else if (cfg_wr && (reg_sel == REG_MAX_ENTRIES)) begin
            max_entries_reg <= pwdata[CNT_W-1:0];
        end
    end

    bdq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd_data  (front_cmd)
    );

    bdq_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    bdq_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .max_entries (max_entries_reg),
        .cmd_valid   (back_valid),
        .cmd_ready   (back_ready),
        .cmd_data    (back_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

@@ design/bdq_checker.sv @@
// ----------------------------------------------------------------------------
// bdq_checker
// port-level checks on the result channel of the bounded deque
// ----------------------------------------------------------------------------
`include "bounded_deque_with_search_top_assert.svh"

module bdq_checker
    import bdq_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input rsp_t m_data
);

    `BDQ_ASSERT_NEXT(a_rsp_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    `BDQ_ASSERT_SAME(a_count_bound, aclk, aresetn, m_valid, m_data.entry_count <= CNT_W'(DEPTH), "entry count above depth")

    `BDQ_ASSERT_SAME(a_err_zero, aclk, aresetn, m_valid && (m_data.status != ST_OK), (m_data.data == '0) && (m_data.position == '0), "error result carries data")

    `BDQ_ASSERT_SAME(a_empty_count, aclk, aresetn, m_valid && (m_data.status == ST_EMPTY), m_data.entry_count == '0, "empty status with entries held")

endmodule

bind bounded_deque_with_search_top bdq_checker u_bdq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ tb/sv/bounded_deque_with_search_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_top_tb
// Drives push, pop, search and remove requests through the valid/ready input
// channel and changes the entry limit over the APB port between phases.
// A behavioral deque model, kept in step with each accepted request, predicts
// every response. Each response is compared field by field, in order.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_top_tb;
    import bdq_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    req_t              s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    rsp_t              m_data;

    // deque model, front at index 0
    logic [HANDLE_W-1:0] held [$];
    logic [CNT_W-1:0]    max_entries_cfg = MAX_ENTRIES_RST;
    rsp_t                pending_rsp [$];
    logic [HANDLE_W-1:0] handle_pool [8];

    int unsigned mismatch_count = 0;
    int unsigned stall_cycles   = 0;
    int unsigned ready_hold     = 0;
    bit          quiet_tail     = 1'b0;

    bounded_deque_with_search_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    function automatic rsp_t predict_deque_op(req_t rq);
        rsp_t        r;
        int unsigned lim;
        int          hit;
        r   = '0;
        lim = (max_entries_cfg > DEPTH) ? DEPTH : max_entries_cfg;
        hit = -1;
        case (rq.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                if (held.size() >= lim) begin
                    r.status = ST_FULL;
                end else if (rq.req_type == REQ_PUSH_FRONT) begin
                    held.push_front(rq.value);
                end else begin
                    held.push_back(rq.value);
                end
            end
            REQ_POP_FRONT: begin
                if (held.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = held.pop_front();
                end
            end
            REQ_POP_REAR: begin
                if (held.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = held.pop_back();
                end
            end
            REQ_SEARCH, REQ_REMOVE: begin
                for (int i = 0; i < held.size(); i++) begin
                    if (hit < 0 && held[i] == rq.value) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.data     = held[hit];
                    r.position = IDX_W'(hit);
                    if (rq.req_type == REQ_REMOVE) begin
                        held.delete(hit);
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = CNT_W'(held.size());
        return r;
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return handle_pool[$urandom_range(0, 7)];
        end else if (r == 4) begin
            return $urandom_range(0, 1) ? '1 : '0;
        end
        return $urandom;
    endfunction

    task automatic report_mismatch(string what, logic [HANDLE_W-1:0] got,
                                   logic [HANDLE_W-1:0] want);
        $display("mismatch %s at %0t: got %h, want %h", what, $realtime, got, want);
        mismatch_count++;
    endtask

    // one input transaction; returns at the rising edge that accepts it
    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic [HANDLE_W-1:0] val);
        req_t rq;
        int   gap;
        rq.req_type = kind;
        rq.value    = val;
        @(negedge aclk);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap     = $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_rsp.push_back(predict_deque_op(rq));
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
    endtask

    task automatic set_max_entries(input logic [CNT_W-1:0] limit);
        logic [DATA_W-1:0] readback;
        drain_results();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_ENTRIES, 2'b00};
        pwdata  <= DATA_W'(limit);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        max_entries_cfg = limit;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        readback = prdata;
        if (readback[CNT_W-1:0] !== limit) begin
            report_mismatch("max_entries readback", HANDLE_W'(readback[CNT_W-1:0]),
                            HANDLE_W'(limit));
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_empty_deque();
        send_request(REQ_POP_FRONT, 32'h0000_0000);
        send_request(REQ_POP_REAR, 32'hFFFF_FFFF);
        send_request(REQ_SEARCH, 32'h0000_0000);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF);
        send_request(REQ_UNUSED_6, 32'hDEAD_BEEF);
        send_request(REQ_UNUSED_7, 32'h0000_0001);
    endtask

    task automatic test_push_pop_order();
        send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(REQ_PUSH_REAR, 32'h0000_0000);
        send_request(REQ_PUSH_FRONT, 32'h5555_5555);
        send_request(REQ_PUSH_REAR, 32'hAAAA_AAAA);
        send_request(REQ_POP_FRONT, 32'h0000_0000);
        send_request(REQ_POP_REAR, 32'hFFFF_FFFF);
    endtask

    task automatic test_search_remove();
        send_request(REQ_PUSH_REAR, 32'hFFFF_FFFF);
        send_request(REQ_SEARCH, 32'hFFFF_FFFF);
        send_request(REQ_SEARCH, 32'h0000_0000);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF);
        send_request(REQ_SEARCH, 32'hFFFF_FFFF);
        send_request(REQ_SEARCH, 32'h1234_5678);
    endtask

    task automatic test_entry_limit();
        // limit below the current count
        set_max_entries(CNT_W'(1));
        send_request(REQ_PUSH_FRONT, 32'h0F0F_0F0F);
        send_request(REQ_POP_REAR, 32'h0000_0000);
        send_request(REQ_PUSH_REAR, 32'hF0F0_F0F0);
        // zero limit refuses every push
        set_max_entries(CNT_W'(0));
        send_request(REQ_PUSH_FRONT, 32'h0000_0001);
        send_request(REQ_POP_FRONT, 32'h0000_0000);
        // limit above depth saturates
        set_max_entries(CNT_W'(31));
        send_request(REQ_PUSH_REAR, 32'h8000_0001);
        send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFE);
    endtask

    task automatic test_random_traffic();
        int unsigned          phase_max [9];
        int unsigned          phase_len [9];
        int unsigned          r;
        bit                   filling;
        logic [REQ_W-1:0]     kind;
        logic [HANDLE_W-1:0]  val;
        phase_max = '{16, 1, 2, 31, 0, 5, 0, 0, 16};
        phase_len = '{300, 150, 150, 300, 30, 200, 250, 250, 300};
        phase_max[6] = $urandom_range(3, 15);
        phase_max[7] = $urandom_range(17, 30);
        filling = 1'b1;
        for (int p = 0; p < 9; p++) begin
            if (p == 8) begin
                quiet_tail = 1'b1;
            end
            set_max_entries(CNT_W'(phase_max[p]));
            for (int i = 0; i < phase_len[p]; i++) begin
                if (i % 24 == 0) begin
                    filling = $urandom_range(0, 1);
                end
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    kind = (r == 0) ? REQ_UNUSED_6 : REQ_UNUSED_7;
                end else if (r < (filling ? 52 : 22)) begin
                    kind = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
                end else if (r < 75) begin
                    kind = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_REAR;
                end else if (r < 88) begin
                    kind = REQ_SEARCH;
                end else begin
                    kind = REQ_REMOVE;
                end
                if ((kind == REQ_SEARCH || kind == REQ_REMOVE) && held.size() > 0
                        && $urandom_range(0, 9) < 7) begin
                    val = held[$urandom_range(0, held.size() - 1)];
                end else if (kind == REQ_POP_FRONT || kind == REQ_POP_REAR
                        || kind == REQ_UNUSED_6 || kind == REQ_UNUSED_7) begin
                    val = $urandom;
                end else begin
                    val = pick_handle();
                end
                send_request(kind, val);
            end
        end
    endtask

    // result channel back-pressure
    always @(negedge aclk) begin
        if (quiet_tail) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 4);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected transaction", m_data.data, '0);
            end else begin
                want = pending_rsp.pop_front();
                if (m_data.status !== want.status) begin
                    report_mismatch("status", HANDLE_W'(m_data.status), HANDLE_W'(want.status));
                end
                if (m_data.data !== want.data) begin
                    report_mismatch("data", m_data.data, want.data);
                end
                if (m_data.position !== want.position) begin
                    report_mismatch("position", HANDLE_W'(m_data.position),
                                    HANDLE_W'(want.position));
                end
                if (m_data.entry_count !== want.entry_count) begin
                    report_mismatch("entry_count", HANDLE_W'(m_data.entry_count),
                                    HANDLE_W'(want.entry_count));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < 8; i++) begin
            handle_pool[i] = $urandom;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_deque();
        test_push_pop_order();
        test_search_remove();
        test_entry_limit();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
